[rtl/core/nosc_pkg.sv]
// ---------------------------------------------------------------------------
// nosc_pkg
// Shared types, codes and byte classification for the natural order compare.
// ---------------------------------------------------------------------------
package nosc_pkg;

    typedef struct packed {
        logic       kind;
        logic [7:0] char_code;
    } item_t;

    typedef struct packed {
        logic signed [1:0] order;
        logic              truncated;
    } result_t;

    typedef struct packed {
        logic       en;
        logic       sel;
        logic [7:0] data;
    } wr_t;

    typedef enum logic [1:0] {
        CLS_END,
        CLS_NUM,
        CLS_TEXT
    } cls_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHUNK,
        ST_TEXT,
        ST_SKIP,
        ST_LEN,
        ST_DIGIT,
        ST_FOLD
    } state_t;

    localparam logic       KIND_FIRST  = 1'b0;
    localparam logic       KIND_SECOND = 1'b1;
    localparam logic [7:0] CH_NUL      = 8'h00;
    localparam logic [7:0] CH_ZERO     = 8'h30;
    localparam logic [7:0] CH_NINE     = 8'h39;
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_UP_A     = 8'h41;
    localparam logic [7:0] CH_UP_Z     = 8'h5A;
    localparam logic [7:0] CASE_OFFS   = 8'h20;

    localparam logic signed [1:0] ORD_LT = 2'sb11;
    localparam logic signed [1:0] ORD_EQ = 2'sb00;
    localparam logic signed [1:0] ORD_GT = 2'sb01;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c);
        return ((c >= CH_UP_A) && (c <= CH_UP_Z)) ? c + CASE_OFFS : c;
    endfunction

    function automatic cls_t classify(input logic [7:0] c);
        cls_t r;
        if (c == CH_NUL)
        begin
            r = CLS_END;
        end
        else if (is_digit(c) || is_space(c))
        begin
            r = CLS_NUM;
        end
        else
        begin
            r = CLS_TEXT;
        end
        return r;
    endfunction

    function automatic logic [7:0] text_key(input logic [7:0] c);
        return (classify(c) == CLS_TEXT) ? fold(c) : CH_NUL;
    endfunction

endpackage

[rtl/core/nosc_front.sv]
// ---------------------------------------------------------------------------
// nosc_front
// Accepts string bytes, keeps the fill counts and issues compare commands.
// ---------------------------------------------------------------------------
module nosc_front #(
    parameter int MAX_LEN = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  nosc_pkg::item_t                item,
    output nosc_pkg::wr_t                  wr,
    output logic [$clog2(MAX_LEN)-1:0]     wr_addr,
    output logic                           push,
    output logic [2*($clog2(MAX_LEN)+1):0] push_data
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = AW + 1;
    localparam logic [CW-1:0] CAP = CW'(MAX_LEN);

    logic [CW-1:0] cnt_a_reg, cnt_a_next;
    logic [CW-1:0] cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic          take;
    logic [CW-1:0] cur_cnt;

    assign take    = start && !busy;
    assign cur_cnt = (item.kind == nosc_pkg::KIND_SECOND) ? cnt_b_reg : cnt_a_reg;
    assign wr_addr = cur_cnt[AW-1:0];

    always_comb
    begin
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        wr.en      = 1'b0;
        wr.sel     = item.kind;
        wr.data    = item.char_code;
        push       = 1'b0;
        push_data  = {ovf_reg, cnt_b_reg, cnt_a_reg};
        if (take)
        begin
            if (item.char_code != nosc_pkg::CH_NUL)
            begin
                if (cur_cnt < CAP)
                begin
                    wr.en = 1'b1;
                    if (item.kind == nosc_pkg::KIND_SECOND)
                    begin
                        cnt_b_next = cnt_b_reg + CW'(1);
                    end
                    else
                    begin
                        cnt_a_next = cnt_a_reg + CW'(1);
                    end
                end
                else
                begin
                    ovf_next = 1'b1;
                end
            end
            else if (item.kind == nosc_pkg::KIND_SECOND)
            begin
                // hand the loaded pair to the back end and start afresh
                push       = 1'b1;
                cnt_a_next = '0;
                cnt_b_next = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_a_reg <= '0;
            cnt_b_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            cnt_a_reg <= cnt_a_next;
            cnt_b_reg <= cnt_b_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

[rtl/core/nosc_queue.sv]
// ---------------------------------------------------------------------------
// nosc_queue
// Two-entry command queue between the front and back ends.
// ---------------------------------------------------------------------------
module nosc_queue #(
    parameter int WIDTH = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data,
    output logic             empty
);

    logic [WIDTH-1:0] slot_reg [2];
    logic             wp_reg, wp_next;
    logic             rp_reg, rp_next;
    logic [1:0]       fill_reg, fill_next;

    assign empty    = (fill_reg == 2'd0);
    assign pop_data = slot_reg[rp_reg];

    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        fill_next = fill_reg;
        if (push && (fill_reg != 2'd2))
        begin
            wp_next   = !wp_reg;
            fill_next = fill_next + 2'd1;
        end
        if (pop && !empty)
        begin
            rp_next   = !rp_reg;
            fill_next = fill_next - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && (fill_reg != 2'd2))
        begin
            slot_reg[wp_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= 1'b0;
            rp_reg   <= 1'b0;
            fill_reg <= 2'd0;
        end
        else
        begin
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
            fill_reg <= fill_next;
        end
    end

endmodule

[rtl/core/nosc_back.sv]
// ---------------------------------------------------------------------------
// nosc_back
// Holds both strings and walks them chunk by chunk to find their order.
// ---------------------------------------------------------------------------
module nosc_back #(
    parameter int MAX_LEN = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nosc_pkg::wr_t                  wr,
    input  logic [$clog2(MAX_LEN)-1:0]     wr_addr,
    input  logic                           q_empty,
    input  logic [2*($clog2(MAX_LEN)+1):0] q_data,
    output logic                           pop,
    output logic                           running,
    output logic                           done,
    output nosc_pkg::result_t              result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = AW + 1;

    logic [7:0] mem_a [MAX_LEN];
    logic [7:0] mem_b [MAX_LEN];
    logic [7:0] rd_a_reg, rd_b_reg;
    logic       inr_a_reg, inr_b_reg;

    nosc_pkg::state_t state_reg, state_next;
    logic          ph_reg, ph_next;
    logic [CW-1:0] pa_reg, pa_next, pb_reg, pb_next;
    logic [CW-1:0] sa_reg, sa_next, sb_reg, sb_next;
    logic [CW-1:0] ea_reg, ea_next;
    logic [CW-1:0] cnt_a_reg, cnt_a_next, cnt_b_reg, cnt_b_next;
    logic          ovf_reg, ovf_next;
    logic          done_reg, done_next;
    logic signed [1:0] ord_reg, ord_next;

    logic [7:0]    ba, bb, xa, xb;
    logic          stop_a, stop_b;
    logic [CW-1:0] la, lb;
    nosc_pkg::cls_t ta, tb;

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.sel == nosc_pkg::KIND_FIRST))
        begin
            mem_a[wr_addr] <= wr.data;
        end
        rd_a_reg  <= mem_a[pa_reg[AW-1:0]];
        inr_a_reg <= pa_reg < cnt_a_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (wr.sel == nosc_pkg::KIND_SECOND))
        begin
            mem_b[wr_addr] <= wr.data;
        end
        rd_b_reg  <= mem_b[pb_reg[AW-1:0]];
        inr_b_reg <= pb_reg < cnt_b_reg;
    end

    // bytes past the stored length read as the terminator
    assign ba = inr_a_reg ? rd_a_reg : nosc_pkg::CH_NUL;
    assign bb = inr_b_reg ? rd_b_reg : nosc_pkg::CH_NUL;
    assign ta = nosc_pkg::classify(ba);
    assign tb = nosc_pkg::classify(bb);

    assign running          = (state_reg != nosc_pkg::ST_IDLE);
    assign done             = done_reg;
    assign result.order     = ord_reg;
    assign result.truncated = ovf_reg;

    always_comb
    begin
        state_next = state_reg;
        ph_next    = ph_reg;
        pa_next    = pa_reg;
        pb_next    = pb_reg;
        sa_next    = sa_reg;
        sb_next    = sb_reg;
        ea_next    = ea_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        ovf_next   = ovf_reg;
        ord_next   = ord_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        xa         = nosc_pkg::CH_NUL;
        xb         = nosc_pkg::CH_NUL;
        stop_a     = 1'b1;
        stop_b     = 1'b1;
        la         = pa_reg - sa_reg;
        lb         = pb_reg - sb_reg;
        if (state_reg == nosc_pkg::ST_IDLE)
        begin
            if (!q_empty)
            begin
                pop        = 1'b1;
                cnt_a_next = q_data[CW-1:0];
                cnt_b_next = q_data[2*CW-1:CW];
                ovf_next   = q_data[2*CW];
                pa_next    = '0;
                pb_next    = '0;
                ph_next    = 1'b0;
                state_next = nosc_pkg::ST_CHUNK;
            end
        end
        else if (!ph_reg)
        begin
            // let the read data settle for the current pointers
            ph_next = 1'b1;
        end
        else
        begin
            ph_next = 1'b0;
            unique case (state_reg)
                nosc_pkg::ST_CHUNK:
                begin
                    priority if (ta == nosc_pkg::CLS_END)
                    begin
                        ord_next   = (tb == nosc_pkg::CLS_END) ? nosc_pkg::ORD_EQ
                                                               : nosc_pkg::ORD_LT;
                        done_next  = 1'b1;
                        state_next = nosc_pkg::ST_IDLE;
                    end
                    else if (tb == nosc_pkg::CLS_END)
                    begin
                        ord_next   = nosc_pkg::ORD_GT;
                        done_next  = 1'b1;
                        state_next = nosc_pkg::ST_IDLE;
                    end
                    else if (ta != tb)
                    begin
                        state_next = nosc_pkg::ST_FOLD;
                    end
                    else if (ta == nosc_pkg::CLS_TEXT)
                    begin
                        state_next = nosc_pkg::ST_TEXT;
                    end
                    else
                    begin
                        state_next = nosc_pkg::ST_SKIP;
                    end
                end
                nosc_pkg::ST_TEXT, nosc_pkg::ST_FOLD:
                begin
                    if (state_reg == nosc_pkg::ST_TEXT)
                    begin
                        xa = nosc_pkg::text_key(ba);
                        xb = nosc_pkg::text_key(bb);
                    end
                    else
                    begin
                        xa = nosc_pkg::fold(ba);
                        xb = nosc_pkg::fold(bb);
                    end
                    priority if (xa != xb)
                    begin
                        ord_next   = (xa < xb) ? nosc_pkg::ORD_LT : nosc_pkg::ORD_GT;
                        done_next  = 1'b1;
                        state_next = nosc_pkg::ST_IDLE;
                    end
                    else if (xa == nosc_pkg::CH_NUL)
                    begin
                        // both text runs end here: next chunk, or equal overall
                        if (state_reg == nosc_pkg::ST_TEXT)
                        begin
                            state_next = nosc_pkg::ST_CHUNK;
                        end
                        else
                        begin
                            ord_next   = nosc_pkg::ORD_EQ;
                            done_next  = 1'b1;
                            state_next = nosc_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        pa_next = pa_reg + CW'(1);
                        pb_next = pb_reg + CW'(1);
                    end
                end
                nosc_pkg::ST_SKIP:
                begin
                    stop_a = !((ba == nosc_pkg::CH_ZERO) || nosc_pkg::is_space(ba));
                    stop_b = !((bb == nosc_pkg::CH_ZERO) || nosc_pkg::is_space(bb));
                    if (!stop_a)
                    begin
                        pa_next = pa_reg + CW'(1);
                    end
                    if (!stop_b)
                    begin
                        pb_next = pb_reg + CW'(1);
                    end
                    if (stop_a && stop_b)
                    begin
                        sa_next    = pa_reg;
                        sb_next    = pb_reg;
                        state_next = nosc_pkg::ST_LEN;
                    end
                end
                nosc_pkg::ST_LEN:
                begin
                    stop_a = !nosc_pkg::is_digit(ba);
                    stop_b = !nosc_pkg::is_digit(bb);
                    if (!stop_a)
                    begin
                        pa_next = pa_reg + CW'(1);
                    end
                    if (!stop_b)
                    begin
                        pb_next = pb_reg + CW'(1);
                    end
                    if (stop_a && stop_b)
                    begin
                        if (la != lb)
                        begin
                            ord_next   = (la < lb) ? nosc_pkg::ORD_LT : nosc_pkg::ORD_GT;
                            done_next  = 1'b1;
                            state_next = nosc_pkg::ST_IDLE;
                        end
                        else
                        begin
                            // rewind to the first significant digit
                            ea_next    = pa_reg;
                            pa_next    = sa_reg;
                            pb_next    = sb_reg;
                            state_next = nosc_pkg::ST_DIGIT;
                        end
                    end
                end
                nosc_pkg::ST_DIGIT:
                begin
                    priority if (pa_reg == ea_reg)
                    begin
                        state_next = nosc_pkg::ST_CHUNK;
                    end
                    else if (ba != bb)
                    begin
                        ord_next   = (ba < bb) ? nosc_pkg::ORD_LT : nosc_pkg::ORD_GT;
                        done_next  = 1'b1;
                        state_next = nosc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        pa_next = pa_reg + CW'(1);
                        pb_next = pb_reg + CW'(1);
                    end
                end
                default:
                begin
                    state_next = nosc_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= nosc_pkg::ST_IDLE;
            ph_reg    <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ph_reg    <= ph_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pa_reg    <= pa_next;
        pb_reg    <= pb_next;
        sa_reg    <= sa_next;
        sb_reg    <= sb_next;
        ea_reg    <= ea_next;
        cnt_a_reg <= cnt_a_next;
        cnt_b_reg <= cnt_b_next;
        ovf_reg   <= ovf_next;
        ord_reg   <= ord_next;
    end

endmodule

[rtl/core/natural_order_string_compare.sv]
// ---------------------------------------------------------------------------
// natural_order_string_compare
// Loads two zero-ended byte strings and reports their natural sort order.
//
//   channel  ports                 transfer
//   item     start, busy, item     rising edge with start high, busy low
//   result   done, result          rising edge ending the cycle done is high
//
// String bytes are taken while busy is low. The second string's zero byte
// queues a compare; the back end then walks both memories in steps, each a
// fetch phase followed by an evaluate phase, with numeric chunks walked twice
// (length, then digits). busy stays high until done.
// Reset clears the front end's fill counts and the control state; string
// memories are not cleared. The receiver cannot stall: done is high for one cycle only.
// ---------------------------------------------------------------------------
module natural_order_string_compare #(
    parameter int MAX_LEN = 256
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  nosc_pkg::item_t   item,
    output logic              done,
    output nosc_pkg::result_t result
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int QW = 2 * (AW + 1) + 1;

    nosc_pkg::wr_t   wr;
    logic [AW-1:0]   wr_addr;
    logic            push, pop, q_empty, running;
    logic [QW-1:0]   push_data, q_data;

    assign busy = !q_empty || running;

    nosc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .wr        (wr),
        .wr_addr   (wr_addr),
        .push      (push),
        .push_data (push_data)
    );

    nosc_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (q_data),
        .empty     (q_empty)
    );

    nosc_back #(.MAX_LEN(MAX_LEN)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (wr),
        .wr_addr (wr_addr),
        .q_empty (q_empty),
        .q_data  (q_data),
        .pop     (pop),
        .running (running),
        .done    (done),
        .result  (result)
    );

endmodule
